### rtl/ckblit_pkg.sv
// Shared types and constants of the color-keyed sprite blitter.
`default_nettype none

package ckblit_pkg;

  // Largest sprite or screen dimension; larger register values saturate to it.
  localparam logic [10:0] MAX_DIM = 11'd1024;

  // Pure green in RGB565 marks transparent sprite pixels.
  localparam logic [15:0] KEY_COLOR = 16'd2016;

  // Widths of the fields.
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned ADDR_W = 20;
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned CFG_W  = 12;
  localparam int unsigned IDX_W  = 3;
  // Screen positions reach from -3072 to 3070.
  localparam int unsigned SPOS_W = 13;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_SPRITE_X      = 3'd0,
    REG_SPRITE_Y      = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_ALIGN_MODE    = 3'd4,
    REG_SCREEN_HRES   = 3'd5,
    REG_SCREEN_VRES   = 3'd6,
    REG_TARGET_SELECT = 3'd7
  } cfg_idx_e;

  // Horizontal alignment codes; the unused code behaves as left.
  typedef enum logic [1:0] {
    ALIGN_LEFT = 2'd0,
    ALIGN_MID  = 2'd1,
    ALIGN_END  = 2'd2
  } align_e;

  // Register file contents, dimensions already saturated.
  typedef struct packed {
    logic signed [POS_W-1:0] sprite_x;
    logic signed [POS_W-1:0] sprite_y;
    logic [DIM_W-1:0]        sprite_width;
    logic [DIM_W-1:0]        sprite_height;
    logic [1:0]              align_mode;
    logic [DIM_W-1:0]        screen_hres;
    logic [DIM_W-1:0]        screen_vres;
    logic                    target_select;
  } cfg_t;

  // One pixel with its screen position, held in the input stage.
  typedef struct packed {
    logic [PIX_W-1:0]         pixel;
    logic signed [SPOS_W-1:0] col;
    logic signed [SPOS_W-1:0] row;
  } stage_t;

  // Payload of one framebuffer write.
  typedef struct packed {
    logic [ADDR_W-1:0] write_addr;
    logic [PIX_W-1:0]  write_data;
    logic              write_target;
  } wr_t;

  // Clamp a dimension register value to MAX_DIM.
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    sat_dim = (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

endpackage

`default_nettype wire

### rtl/ckblit_pix_if.sv
// Stream interface that carries source pixels.
`default_nettype none

interface ckblit_pix_if;
  import ckblit_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

`default_nettype wire

### rtl/ckblit_wr_if.sv
// Stream interface that carries framebuffer writes.
`default_nettype none

interface ckblit_wr_if;
  import ckblit_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_addr;
  logic [PIX_W-1:0]  write_data;
  logic              write_target;

  modport source (output valid, output write_addr, output write_data,
                  output write_target, input ready);
  modport sink (input valid, input write_addr, input write_data,
                input write_target, output ready);
endinterface

`default_nettype wire

### rtl/ckblit_regs.sv
// Configuration registers of the blitter with dimension saturation.
`default_nettype none

module ckblit_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ckblit_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [ckblit_pkg::CFG_W-1:0] cfg_data_i,
  output ckblit_pkg::cfg_t                 cfg_o
);
  import ckblit_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode one register write; dimensions are clamped as they are stored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_SPRITE_X:      cfg_d.sprite_x      = cfg_data_i[POS_W-1:0];
        REG_SPRITE_Y:      cfg_d.sprite_y      = cfg_data_i[POS_W-1:0];
        REG_SPRITE_WIDTH:  cfg_d.sprite_width  = sat_dim(cfg_data_i[DIM_W-1:0]);
        REG_SPRITE_HEIGHT: cfg_d.sprite_height = sat_dim(cfg_data_i[DIM_W-1:0]);
        REG_ALIGN_MODE:    cfg_d.align_mode    = cfg_data_i[1:0];
        REG_SCREEN_HRES:   cfg_d.screen_hres   = sat_dim(cfg_data_i[DIM_W-1:0]);
        REG_SCREEN_VRES:   cfg_d.screen_vres   = sat_dim(cfg_data_i[DIM_W-1:0]);
        REG_TARGET_SELECT: cfg_d.target_select = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sprite_x      <= '0;
      cfg_q.sprite_y      <= '0;
      cfg_q.sprite_width  <= 11'd1;
      cfg_q.sprite_height <= 11'd1;
      cfg_q.align_mode    <= ALIGN_LEFT;
      cfg_q.screen_hres   <= 11'd1024;
      cfg_q.screen_vres   <= 11'd768;
      cfg_q.target_select <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/ckblit_pos.sv
// Source counters and input stage that places each pixel on the screen.
`default_nettype none

module ckblit_pos (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ckblit_pkg::cfg_t cfg_i,
  ckblit_pix_if.sink          pix_i,
  input  wire logic           out_free_i,
  output logic                s1_valid_o,
  output ckblit_pkg::stage_t  s1_o
);
  import ckblit_pkg::*;

  logic [DIM_W-1:0]         col_cnt_q, col_cnt_d;
  logic [DIM_W-1:0]         row_cnt_q, row_cnt_d;
  logic [DIM_W-1:0]         col_inc, row_inc;
  logic                     s1_valid_q, s1_valid_d;
  stage_t                   s1_q;
  logic                     accept;
  logic signed [SPOS_W-1:0] x_shift, x0, col_pos, row_pos;

  // The stage takes a pixel when it is empty or its content moves on.
  assign pix_i.ready = !s1_valid_q || out_free_i;
  assign accept      = pix_i.valid && pix_i.ready;

  // Alignment offset of the sprite's left edge.
  always_comb begin
    unique case (cfg_i.align_mode)
      ALIGN_MID: x_shift = SPOS_W'({1'b0, cfg_i.sprite_width[DIM_W-1:1]});
      ALIGN_END: x_shift = SPOS_W'(cfg_i.sprite_width);
      default:   x_shift = '0;
    endcase
  end

  // Screen position of the current source pixel; rows are stored bottom-up.
  always_comb begin
    x0      = SPOS_W'(cfg_i.sprite_x) - x_shift;
    col_pos = x0 + SPOS_W'(col_cnt_q);
    row_pos = SPOS_W'(cfg_i.sprite_y) + SPOS_W'(cfg_i.sprite_height)
              - SPOS_W'(1) - SPOS_W'(row_cnt_q);
  end

  // Column and row counters wrap at the sprite size; a zero size acts as one.
  always_comb begin
    col_inc   = col_cnt_q + 11'd1;
    row_inc   = row_cnt_q + 11'd1;
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (accept) begin
      if (col_inc >= cfg_i.sprite_width) begin
        col_cnt_d = '0;
        row_cnt_d = (row_inc >= cfg_i.sprite_height) ? '0 : row_inc;
      end else begin
        col_cnt_d = col_inc;
      end
    end
  end

  assign s1_valid_d = pix_i.ready ? accept : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_cnt_q  <= col_cnt_d;
      row_cnt_q  <= row_cnt_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.pixel <= pix_i.pixel;
      s1_q.col   <= col_pos;
      s1_q.row   <= row_pos;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

  // Counters stay below the largest sprite size.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_cnt_q < MAX_DIM) && (row_cnt_q < MAX_DIM))
    else $error("source counter out of range");

  // A held stage keeps its pixel while the output side is blocked.
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free_i |=> s1_valid_q && $stable(s1_q))
    else $error("input stage lost a pixel under stall");

endmodule

`default_nettype wire

### rtl/ckblit_emit.sv
// Clip and key test, address multiply and the result register.
`default_nettype none

module ckblit_emit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ckblit_pkg::cfg_t   cfg_i,
  input  wire logic          s1_valid_i,
  input  wire ckblit_pkg::stage_t s1_i,
  output logic               out_free_o,
  ckblit_wr_if.source        wr_o
);
  import ckblit_pkg::*;

  logic              out_valid_q, out_valid_d;
  wr_t               out_q;
  logic              on_screen, hit;
  logic [20:0]       row_prod;
  logic [ADDR_W-1:0] addr;

  // Position must fall inside the screen and the pixel must not be keyed out.
  always_comb begin
    on_screen = !s1_i.col[SPOS_W-1] && !s1_i.row[SPOS_W-1]
                && (s1_i.col[SPOS_W-2:0] < (SPOS_W-1)'(cfg_i.screen_hres))
                && (s1_i.row[SPOS_W-2:0] < (SPOS_W-1)'(cfg_i.screen_vres));
    hit = on_screen && (s1_i.pixel != KEY_COLOR);
  end

  // On screen both coordinates are below 1024, so ten bits of each suffice.
  always_comb begin
    row_prod = 21'(s1_i.row[9:0]) * 21'(cfg_i.screen_hres);
    addr     = row_prod[ADDR_W-1:0] + ADDR_W'(s1_i.col[9:0]);
  end

  // Result register refills when empty or when its write is transferred.
  assign out_free_o  = !out_valid_q || wr_o.ready;
  assign out_valid_d = out_free_o ? (s1_valid_i && hit) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && s1_valid_i && hit) begin
      out_q.write_addr   <= addr;
      out_q.write_data   <= s1_i.pixel;
      out_q.write_target <= cfg_i.target_select;
    end
  end

  assign wr_o.valid        = out_valid_q;
  assign wr_o.write_addr   = out_q.write_addr;
  assign wr_o.write_data   = out_q.write_data;
  assign wr_o.write_target = out_q.write_target;

  // A keyed pixel never reaches the framebuffer.
  a_no_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.write_data != KEY_COLOR)
    else $error("key color written");

  // Every write lands inside the screen.
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> 22'(out_q.write_addr) < 22'(cfg_i.screen_hres) * 22'(cfg_i.screen_vres))
    else $error("write outside the screen");

  // A pixel that passes the tests with room downstream becomes a write.
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_i && hit && out_free_o |=> out_valid_q)
    else $error("visible pixel dropped");

endmodule

`default_nettype wire

### rtl/color_key_sprite_blitter.sv
// Top level of the color-keyed RGB565 sprite blitter.
//
// Usage: source pixels of a bottom-up bitmap enter on pix_i in stored order,
// bottom row first, left to right. For each pixel the block computes its
// screen column (aligned sprite_x plus source column) and screen row
// (sprite_y plus height minus one minus source row). A write leaves on wr_o
// only when that position is on screen and the pixel is not pure green
// (2016); otherwise the pixel is consumed with no transfer.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// no pixel is in flight; dimensions above 1024 are clamped to 1024.
// Each write passes through the input stage and then the result register before
// it is offered on wr_o. Throughput: one pixel per cycle while the receiver takes
// writes; the input stage and the result register each hold one item, and the
// 10 x 11 bit address multiply sits between them.
// Reset clears the source counters and both stages and loads the register
// defaults (1x1 sprite at 0,0, left aligned, 1024 x 768 screen, target select 0).
// When the receiver stalls, the result register holds its write, the input
// stage keeps one more pixel, and pix_i.ready drops only after both are full.
// The counters return to zero after the last pixel of a frame.
`default_nettype none

module color_key_sprite_blitter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ckblit_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [ckblit_pkg::CFG_W-1:0] cfg_data_i,
  ckblit_pix_if.sink                       pix_i,
  ckblit_wr_if.source                      wr_o
);
  import ckblit_pkg::*;

  cfg_t   cfg;
  stage_t s1;
  logic   s1_valid;
  logic   out_free;

  ckblit_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ckblit_pos u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pix_i      (pix_i),
    .out_free_i (out_free),
    .s1_valid_o (s1_valid),
    .s1_o       (s1)
  );

  ckblit_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .out_free_o (out_free),
    .wr_o       (wr_o)
  );

endmodule

`default_nettype wire

### tb/sv/blit_checker.sv
// Checker that predicts the blitter's framebuffer writes and compares them with its output.
`timescale 1ns / 100ps

module blit_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ckblit_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [ckblit_pkg::CFG_W-1:0] cfg_data_i,
  ckblit_pix_if                        pix_i,
  ckblit_wr_if                         wr_i,
  output int unsigned                  err_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  write_count_o
);
  import ckblit_pkg::*;

  // Shadow copy of the register file, held at register width.
  logic [POS_W-1:0] anchor_x;
  logic [POS_W-1:0] anchor_y;
  logic [DIM_W-1:0] bmp_width;
  logic [DIM_W-1:0] bmp_height;
  logic [1:0]       align_sel;
  logic [DIM_W-1:0] view_hres;
  logic [DIM_W-1:0] view_vres;
  logic             buf_sel;

  // Source position of the next pixel.
  logic [DIM_W-1:0] src_col;
  logic [DIM_W-1:0] src_row;

  // Framebuffer writes that the block still owes, oldest first.
  wr_t pending_writes[$];

  // Dimensions above the maximum count as the maximum.
  function automatic int clamp_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? int'(MAX_DIM) : int'(v);
  endfunction

  // Register writes, pixel transfers and write transfers, all sampled at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    int  w;
    int  h;
    int  hres;
    int  vres;
    int  x0;
    int  col;
    int  row;
    wr_t want;
    wr_t seen;
    if (!rst_ni) begin
      anchor_x      = '0;
      anchor_y      = '0;
      bmp_width     = DIM_W'(1);
      bmp_height    = DIM_W'(1);
      align_sel     = ALIGN_LEFT;
      view_hres     = DIM_W'(1024);
      view_vres     = DIM_W'(768);
      buf_sel       = 1'b0;
      src_col       = '0;
      src_row       = '0;
      pending_writes.delete();
      err_count_o   = 0;
      write_count_o = 0;
      pending_o     = 0;
    end else begin
      // Register write.
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_SPRITE_X:      anchor_x   = cfg_data_i[POS_W-1:0];
          REG_SPRITE_Y:      anchor_y   = cfg_data_i[POS_W-1:0];
          REG_SPRITE_WIDTH:  bmp_width  = cfg_data_i[DIM_W-1:0];
          REG_SPRITE_HEIGHT: bmp_height = cfg_data_i[DIM_W-1:0];
          REG_ALIGN_MODE:    align_sel  = cfg_data_i[1:0];
          REG_SCREEN_HRES:   view_hres  = cfg_data_i[DIM_W-1:0];
          REG_SCREEN_VRES:   view_vres  = cfg_data_i[DIM_W-1:0];
          REG_TARGET_SELECT: buf_sel    = cfg_data_i[0];
          default: ;
        endcase
      end

      // Pixel transfer: place it on screen and decide whether it is written.
      if (pix_i.valid && pix_i.ready) begin
        w    = clamp_dim(bmp_width);
        h    = clamp_dim(bmp_height);
        hres = clamp_dim(view_hres);
        vres = clamp_dim(view_vres);
        x0   = int'($signed(anchor_x));
        if (align_sel == ALIGN_MID) begin
          x0 = x0 - w / 2;
        end else if (align_sel == ALIGN_END) begin
          x0 = x0 - w;
        end
        col = x0 + int'(src_col);
        row = int'($signed(anchor_y)) + h - 1 - int'(src_row);
        if (col >= 0 && col < hres && row >= 0 && row < vres &&
            pix_i.pixel != KEY_COLOR) begin
          want.write_addr   = ADDR_W'(row * hres + col);
          want.write_data   = pix_i.pixel;
          want.write_target = buf_sel;
          pending_writes.push_back(want);
        end
        // Step along the row; a bound of zero wraps at every pixel.
        src_col = src_col + 1'b1;
        if (int'(src_col) >= w) begin
          src_col = '0;
          src_row = src_row + 1'b1;
          if (int'(src_row) >= h) begin
            src_row = '0;
          end
        end
      end

      // Write transfer: compare every field with the oldest prediction.
      if (wr_i.valid && wr_i.ready) begin
        seen.write_addr   = wr_i.write_addr;
        seen.write_data   = wr_i.write_data;
        seen.write_target = wr_i.write_target;
        write_count_o++;
        if (pending_writes.size() == 0) begin
          err_count_o++;
          $display("%0t ns: write with none predicted: expected nothing,", $time,
                   " actual addr %0d data %h target %0d",
                   seen.write_addr, seen.write_data, seen.write_target);
        end else begin
          want = pending_writes.pop_front();
          if (seen.write_addr !== want.write_addr || seen.write_data !== want.write_data ||
              seen.write_target !== want.write_target) begin
            err_count_o++;
            $display("%0t ns: write mismatch: expected addr %0d data %h target %0d,",
                     $time, want.write_addr, want.write_data, want.write_target,
                     " actual addr %0d data %h target %0d",
                     seen.write_addr, seen.write_data, seen.write_target);
          end
        end
      end
      pending_o = pending_writes.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// Top of the sprite blitter testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps

module testbench;
  import ckblit_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_PIXELS = 395;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned DRAIN_CYCLES  = 6;
  // The fourth alignment code has no name in the package and acts as left.
  localparam logic [1:0]  ALIGN_UNUSED  = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  int unsigned err_count;
  int unsigned pending;
  int unsigned write_count;
  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;

  // Idling controls shared between the stimulus and the receiver.
  bit send_no_idle;
  bit recv_no_idle;
  bit hold_request;

  ckblit_pix_if pix_if ();
  ckblit_wr_if  wr_if ();

  color_key_sprite_blitter i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .wr_o       (wr_if)
  );

  blit_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .pix_i         (pix_if),
    .wr_i          (wr_if),
    .err_count_o   (err_count),
    .pending_o     (pending),
    .write_count_o (write_count)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Reset is held from the start and then released for the rest of the run.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d writes outstanding.", cycle_count, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Write receiver: random stalls, stretches without stalls, and one long hold-off.
  initial begin : receiver
    int unsigned stall;
    wr_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        wr_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = recv_no_idle ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        wr_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      wr_if.ready <= 1'b1;
      @(posedge clk);
      while (!wr_if.valid) @(posedge clk);
    end
  end

  // Offer one pixel after a random gap, or none while send_no_idle is set; starts and ends at a clock edge.
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    int unsigned gap;
    gap = send_no_idle ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= value;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Stop offering pixels and wait until the block has nothing left in flight.
  task automatic settle();
    pix_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(input int x, input int y, input int w, input int h,
                         input logic [1:0] align, input int hres, input int vres,
                         input logic tgt);
    write_reg(REG_SPRITE_X, x);
    write_reg(REG_SPRITE_Y, y);
    write_reg(REG_SPRITE_WIDTH, w);
    write_reg(REG_SPRITE_HEIGHT, h);
    write_reg(REG_ALIGN_MODE, int'(align));
    write_reg(REG_SCREEN_HRES, hres);
    write_reg(REG_SCREEN_VRES, vres);
    write_reg(REG_TARGET_SELECT, int'(tgt));
  endtask

  // Pixels lean toward the key color and its one-bit neighbors.
  function automatic logic [PIX_W-1:0] draw_pixel();
    case ($urandom_range(0, 9))
      0, 1:    return KEY_COLOR;
      2:       return KEY_COLOR ^ (16'h0001 << $urandom_range(0, 15));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Sprite sizes are mostly small, with zero and oversized values now and then.
  function automatic int draw_sprite_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $urandom_range(1, 8);
    if (pick < 17) return $urandom_range(9, 40);
    if (pick == 17) return 0;
    if (pick == 18) return $urandom_range(1000, 1024);
    return $urandom_range(1025, 2047);
  endfunction

  // Screen sizes favor small screens so that clipping happens on every side.
  function automatic int draw_screen_dim();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 8) return $urandom_range(1, 48);
    if (pick < 11) return 1024;
    if (pick == 11) return 768;
    if (pick == 12) return 0;
    if (pick == 13) return $urandom_range(1025, 2047);
    return $urandom_range(1, 1024);
  endfunction

  // Anchor near the screen so the sprite straddles its edges, or at the extremes.
  function automatic int draw_anchor(input int screen, input int sprite);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 16) return int'($urandom_range(0, screen + 2 * sprite)) - sprite;
    if (pick == 16) return -2048;
    if (pick == 17) return 2047;
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int clamp_dim(input int v);
    return (v > int'(MAX_DIM)) ? int'(MAX_DIM) : v;
  endfunction

  // Stimulus: directed cases, one long receiver stall, then random phases.
  initial begin : stimulus
    int          w;
    int          h;
    int          hres;
    int          vres;
    int          frame;
    int          count;
    int unsigned phases;
    int unsigned random_sent;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_SPRITE_X;
    cfg_data     <= '0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    phases       = 0;
    random_sent  = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Reset defaults: every pixel lands at the origin; the key color and its neighbors.
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(KEY_COLOR);
    send_pixel(KEY_COLOR - 16'd1);
    send_pixel(KEY_COLOR + 16'd1);
    settle();

    // Last pixel of the largest screen; oversized screen values clamp to the maximum.
    set_all(1023, 1023, 1, 1, ALIGN_LEFT, 2047, 1500, 1'b1);
    send_pixel(16'hA5A5);
    settle();

    // A screen of zero size has no visible position.
    set_all(0, 0, 1, 1, ALIGN_LEFT, 0, 0, 1'b0);
    send_pixel(16'h1234);
    send_pixel(16'h5A5A);
    settle();

    // Centered 5 x 2 sprite, two rows stored bottom-up, one keyed pixel.
    set_all(2, 0, 5, 2, ALIGN_MID, 16, 16, 1'b0);
    for (int i = 0; i < 10; i++) begin
      send_pixel((i == 7) ? KEY_COLOR : PIX_W'($urandom));
    end
    settle();

    // Right alignment pushes the sprite past the left edge.
    set_all(1, 5, 3, 1, ALIGN_END, 16, 16, 1'b1);
    for (int i = 0; i < 3; i++) begin
      send_pixel(PIX_W'($urandom));
    end
    settle();

    // Extreme anchors, zero sprite size and the unused alignment code.
    set_all(-2048, -2048, 0, 0, ALIGN_UNUSED, 1024, 768, 1'b0);
    send_pixel(16'h0F0F);
    settle();
    set_all(2047, 2047, 0, 0, ALIGN_UNUSED, 1024, 768, 1'b1);
    send_pixel(16'hF0F0);
    settle();

    // Long receiver hold-off while visible pixels keep coming back to back.
    set_all(0, 0, 4, 4, ALIGN_LEFT, 64, 64, 1'b0);
    send_no_idle = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 32; i++) begin
      send_pixel(KEY_COLOR ^ PIX_W'($urandom_range(1, 65535)));
    end
    settle();
    send_no_idle = 1'b0;

    // Random phases: fresh registers, whole frames and sometimes a partial one.
    while (random_sent < RANDOM_PIXELS) begin
      phases++;
      w    = draw_sprite_dim();
      h    = draw_sprite_dim();
      hres = draw_screen_dim();
      vres = draw_screen_dim();
      send_no_idle = ($urandom_range(0, 4) == 0);
      recv_no_idle = ($urandom_range(0, 4) == 0);
      set_all(draw_anchor(clamp_dim(hres), clamp_dim(w)),
              draw_anchor(clamp_dim(vres), clamp_dim(h)),
              w, h, 2'($urandom_range(0, 3)), hres, vres, 1'($urandom));
      frame = ((w == 0) ? 1 : clamp_dim(w)) * ((h == 0) ? 1 : clamp_dim(h));
      if (frame <= 64) begin
        count = frame * int'($urandom_range(1, 3));
        if ($urandom_range(0, 3) == 0) begin
          count = count + int'($urandom_range(0, frame - 1));
        end
      end else begin
        count = $urandom_range(10, 60);
      end
      // The last phase stops at the planned number of random pixels.
      if (count > int'(RANDOM_PIXELS - random_sent)) begin
        count = int'(RANDOM_PIXELS - random_sent);
      end
      repeat (count) begin
        send_pixel(draw_pixel());
        random_sent++;
      end
      settle();
    end

    $display("Covered %0d pixels (%0d in %0d random register settings) and %0d checked writes,",
             pixels_sent, random_sent, phases, write_count);
    $display("including clipping on all edges, key color, zero and oversized sizes, long stall.");
    if (pending != 0) begin
      $display("%0d predicted writes never arrived.", pending);
    end
    if (err_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
